// File: rtl/block_mean_mosaic_top_macros.svh
// Assertion macros shared by the block mean mosaic RTL.
`ifndef BLOCK_MEAN_MOSAIC_TOP_MACROS_SVH
`define BLOCK_MEAN_MOSAIC_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BMM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/bmm_pkg.sv
// Package with constants and types for the block mean mosaic.
package bmm_pkg;
  localparam int MaxWidthDef = 1024;
  localparam int MaxBlockDef = 16;
  localparam int HeightLimit = 1024;
  localparam int PixW = 8;
  localparam int IdxW = 10;
  localparam int CfgW = 11;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegBlockSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd2;

  typedef struct packed {
    logic [PixW-1:0] pixel_blue;
    logic [PixW-1:0] pixel_green;
    logic [PixW-1:0] pixel_red;
  } pixel_t;

  typedef struct packed {
    logic [IdxW-1:0] block_column;
    logic [IdxW-1:0] block_row;
    logic [PixW-1:0] mean_blue;
    logic [PixW-1:0] mean_green;
    logic [PixW-1:0] mean_red;
  } mean_t;
endpackage

// File: rtl/bmm_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
interface bmm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bmm_divider.sv
// Restoring divider: one quotient bit per cycle for a block mean.
module bmm_divider #(
  parameter int NumW = 24,
  parameter int DenW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] nreg;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dreg;
  logic [CntW-1:0] cnt;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    shifted = {rem[DenW-1:0], nreg[NumW-1]};
    trial = shifted - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntW'(NumW);
      nreg <= num;
      dreg <= den;
      rem <= '0;
      quot <= '0;
    end else if (busy) begin
      nreg <= {nreg[NumW-2:0], 1'b0};
      if (!trial[DenW]) begin
        rem <= trial;
        quot <= {quot[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quot <= {quot[NumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end
endmodule

// File: rtl/block_mean_mosaic_top.sv
// Top level of the block mean mosaic: block-average downsampling of RGB pixels.
// Pixels arrive in raster order, top row first, one beat each. Every pixel that
// falls into a full square block is added into a per-block-column sum held in a
// one-port-read, one-port-write synchronous memory (one 48-bit word per block
// column). A pixel in a full block that does not close it goes from one
// accepted beat to the next through accept, read the sum memory, add and write
// back, then advance the raster counters. A pixel of a partial edge block skips
// the memory and goes from accept straight to advancing the counters. The
// bottom-right pixel of a full block starts three restoring dividers in
// parallel, one quotient bit per cycle over the 18-bit numerator, and waits
// until all three are done and any earlier mean has been accepted. Each
// mean is floor((2*sum+n)/(2n)), n = block_size squared, and leaves through an
// output register so the next pixel is accepted while the result waits; a
// block-closing pixel is held off while an earlier mean is still unaccepted.
// Partial edge blocks give no result. A write to block size, width or height
// restarts the frame; values out of range are clamped (zero reads as one).
module block_mean_mosaic_top
  import bmm_pkg::*;
#(
  parameter int MAX_WIDTH = bmm_pkg::MaxWidthDef,
  parameter int MAX_BLOCK_SIZE = bmm_pkg::MaxBlockDef
) (
  input  logic                        clk,
  input  logic                        rst,
  bmm_stream_if.sink                  pixel_in,
  bmm_stream_if.source                mean_out,
  input  logic                        cfg_we,
  input  logic [bmm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bmm_pkg::CfgW-1:0]    cfg_data
);
  `include "block_mean_mosaic_top_macros.svh"

  localparam int ColAW = $clog2(MAX_WIDTH);
  localparam int BsW = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int SumW = PixW + 2 * $clog2(MAX_BLOCK_SIZE);
  localparam int NumW = SumW + 2;
  localparam int DenW = 2 * BsW + 1;
  localparam int BigW = 24;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ADD, S_DIV, S_OUT} state_t;

  state_t state;
  logic [4:0] block_size;
  logic [CfgW-1:0] image_width, image_height;
  logic [CfgW-1:0] column_count, row_count;
  logic [BsW-1:0] x_in_block, y_in_block;
  logic [CfgW-1:0] block_col_index, block_row_index;
  logic [BsW-1:0] bs;
  logic [CfgW:0] w, h;
  pixel_t pix;
  logic take, use_mem, last_px, first_px;
  logic [BigW-1:0] col_end, row_end;
  logic [3*SumW-1:0] sum_mem [MAX_WIDTH];
  logic [3*SumW-1:0] rd_data;
  logic [ColAW-1:0] addr;
  logic [SumW-1:0] s_b, s_g, s_r;
  logic [DenW-1:0] den;
  logic div_start;
  logic [2:0] div_busy;
  logic [NumW-1:0] q_b, q_g, q_r;
  logic [IdxW-1:0] out_col, out_row;
  mean_t out_reg;
  logic out_valid;

  always_comb begin
    if (block_size == 5'd0) bs = BsW'(1);
    else if (32'(block_size) > MAX_BLOCK_SIZE) bs = BsW'(MAX_BLOCK_SIZE);
    else bs = BsW'(block_size);
    if (image_width == '0) w = (CfgW+1)'(1);
    else if (32'(image_width) > MAX_WIDTH) w = (CfgW+1)'(MAX_WIDTH);
    else w = {1'b0, image_width};
    if (image_height == '0) h = (CfgW+1)'(1);
    else if (32'(image_height) > HeightLimit) h = (CfgW+1)'(HeightLimit);
    else h = {1'b0, image_height};
  end

  always_comb begin
    col_end = (BigW'(block_col_index) + BigW'(1)) * BigW'(bs);
    row_end = (BigW'(block_row_index) + BigW'(1)) * BigW'(bs);
    use_mem = (col_end <= BigW'(w)) && (row_end <= BigW'(h))
              && (32'(block_col_index) < MAX_WIDTH);
    first_px = (x_in_block == '0) && (y_in_block == '0);
    last_px = (BsW'(x_in_block + 1'b1) >= bs) && (BsW'(y_in_block + 1'b1) >= bs);
    take = pixel_in.valid && pixel_in.ready;
    addr = block_col_index[ColAW-1:0];
    pixel_in.ready = (state == S_IDLE) && !(out_valid && !mean_out.ready && use_mem
                      && last_px);
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_data <= sum_mem[addr];
    if (state == S_ADD) sum_mem[addr] <= {s_b, s_g, s_r};
  end

  always_comb begin
    if (first_px) begin
      s_b = SumW'(pix.pixel_blue);
      s_g = SumW'(pix.pixel_green);
      s_r = SumW'(pix.pixel_red);
    end else begin
      s_b = rd_data[3*SumW-1:2*SumW] + SumW'(pix.pixel_blue);
      s_g = rd_data[2*SumW-1:SumW] + SumW'(pix.pixel_green);
      s_r = rd_data[SumW-1:0] + SumW'(pix.pixel_red);
    end
    den = (DenW'(bs) * DenW'(bs)) << 1;
    div_start = (state == S_ADD) && last_px;
  end

  bmm_divider #(.NumW(NumW), .DenW(DenW)) u_div_b (.clk, .rst, .start(div_start),
    .num(({2'b0, s_b} << 1) + NumW'(den >> 1)), .den, .busy(div_busy[0]), .quot(q_b));
  bmm_divider #(.NumW(NumW), .DenW(DenW)) u_div_g (.clk, .rst, .start(div_start),
    .num(({2'b0, s_g} << 1) + NumW'(den >> 1)), .den, .busy(div_busy[1]), .quot(q_g));
  bmm_divider #(.NumW(NumW), .DenW(DenW)) u_div_r (.clk, .rst, .start(div_start),
    .num(({2'b0, s_r} << 1) + NumW'(den >> 1)), .den, .busy(div_busy[2]), .quot(q_r));

  function automatic logic [PixW-1:0] sat8(input logic [NumW-1:0] q);
    return (q > NumW'(255)) ? 8'hFF : q[PixW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      block_size <= 5'd4;
      image_width <= CfgW'(640);
      image_height <= CfgW'(480);
      column_count <= '0;
      row_count <= '0;
      x_in_block <= '0;
      y_in_block <= '0;
      block_col_index <= '0;
      block_row_index <= '0;
    end else begin
      if (out_valid && mean_out.ready) out_valid <= 1'b0;
      if (cfg_we && (cfg_index == RegBlockSize || cfg_index == RegImageWidth
                     || cfg_index == RegImageHeight)) begin
        case (cfg_index)
          RegBlockSize: block_size <= cfg_data[4:0];
          RegImageWidth: image_width <= cfg_data;
          RegImageHeight: image_height <= cfg_data;
          default: ;
        endcase
        column_count <= '0;
        row_count <= '0;
        x_in_block <= '0;
        y_in_block <= '0;
        block_col_index <= '0;
        block_row_index <= '0;
      end
      case (state)
        S_IDLE: if (take) begin
          pix <= pixel_in.data;
          out_col <= block_col_index[IdxW-1:0];
          out_row <= block_row_index[IdxW-1:0];
          if (use_mem) state <= S_READ;
          else state <= S_OUT;
        end
        S_READ: state <= S_ADD;
        S_ADD: state <= last_px ? S_DIV : S_OUT;
        S_DIV: if (div_busy == 3'b000 && !out_valid) begin
          out_reg <= '{block_column: out_col, block_row: out_row, mean_blue: sat8(q_b),
                       mean_green: sat8(q_g), mean_red: sat8(q_r)};
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
          if (BsW'(x_in_block + 1'b1) >= bs) begin
            x_in_block <= '0;
            block_col_index <= block_col_index + 1'b1;
          end else begin
            x_in_block <= x_in_block + 1'b1;
          end
          column_count <= column_count + 1'b1;
          if ({1'b0, column_count} + 1'b1 >= w) begin
            column_count <= '0;
            x_in_block <= '0;
            block_col_index <= '0;
            if (BsW'(y_in_block + 1'b1) >= bs) begin
              y_in_block <= '0;
              block_row_index <= block_row_index + 1'b1;
            end else begin
              y_in_block <= y_in_block + 1'b1;
            end
            row_count <= row_count + 1'b1;
            if ({1'b0, row_count} + 1'b1 >= h) begin
              row_count <= '0;
              y_in_block <= '0;
              block_row_index <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mean_out.valid = out_valid;
  assign mean_out.data = out_reg;

  `BMM_ASSERT_IMP(a_ready_idle, pixel_in.ready, state == S_IDLE)
  `BMM_ASSERT_NEXT(a_take_leaves_idle, take, state != S_IDLE)
  `BMM_ASSERT_NEXT(a_read_then_add, state == S_READ, state == S_ADD)
  `BMM_ASSERT_IMP(a_div_lockstep, state == S_DIV, div_busy == 3'b000 || div_busy == 3'b111)
endmodule

// File: dv/bmm_mean_checker.sv
// Checker for the block mean mosaic: predicts block means and compares output beats.
module bmm_mean_checker
  import bmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  input  logic               pix_ready,
  input  pixel_t             pix_data,
  input  logic               mean_valid,
  input  logic               mean_ready,
  input  mean_t              mean_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending_means
);

  logic [4:0]  blk_reg;
  logic [10:0] wid_reg;
  logic [10:0] hgt_reg;
  int unsigned col_pos, row_pos, x_pos, y_pos, bcol, brow;
  int unsigned col_sum [MaxWidthDef][3];
  mean_t       mean_queue [$];

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    col_pos = 0; row_pos = 0; x_pos = 0; y_pos = 0; bcol = 0; brow = 0;
  endtask

  // Accumulate one pixel and queue a mean when it closes a full block.
  task automatic accumulate_pixel(pixel_t p);
    int unsigned bs, w, h, n, m;
    int unsigned px [3];
    mean_t r;
    bs = clamp_cfg(blk_reg, MaxBlockDef);
    w  = clamp_cfg(wid_reg, MaxWidthDef);
    h  = clamp_cfg(hgt_reg, HeightLimit);
    px[0] = p.pixel_blue; px[1] = p.pixel_green; px[2] = p.pixel_red;
    if ((bcol + 1) * bs <= w && (brow + 1) * bs <= h) begin
      for (int c = 0; c < 3; c++)
        col_sum[bcol][c] = (x_pos == 0 && y_pos == 0) ? px[c] : col_sum[bcol][c] + px[c];
      if (x_pos + 1 >= bs && y_pos + 1 >= bs) begin
        n = bs * bs;
        r.block_column = bcol[IdxW-1:0];
        r.block_row = brow[IdxW-1:0];
        m = (2 * col_sum[bcol][0] + n) / (2 * n); r.mean_blue  = (m > 255) ? 8'hFF : m[7:0];
        m = (2 * col_sum[bcol][1] + n) / (2 * n); r.mean_green = (m > 255) ? 8'hFF : m[7:0];
        m = (2 * col_sum[bcol][2] + n) / (2 * n); r.mean_red   = (m > 255) ? 8'hFF : m[7:0];
        mean_queue.push_back(r);
      end
    end
    x_pos++;
    if (x_pos >= bs) begin
      x_pos = 0;
      bcol++;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0; x_pos = 0; bcol = 0;
      y_pos++;
      if (y_pos >= bs) begin
        y_pos = 0;
        brow++;
      end
      row_pos++;
      if (row_pos >= h) restart_frame();
    end
  endtask

  task automatic compare_mean(mean_t got);
    mean_t want;
    if (mean_queue.size() == 0) begin
      $error("mean beat with no block pending: %p", got);
      fail_count++;
      return;
    end
    want = mean_queue.pop_front();
    if (got.block_column !== want.block_column) begin
      $error("block_column expected %0d got %0d", want.block_column, got.block_column);
      fail_count++;
    end
    if (got.block_row !== want.block_row) begin
      $error("block_row expected %0d got %0d", want.block_row, got.block_row);
      fail_count++;
    end
    if (got.mean_blue !== want.mean_blue) begin
      $error("mean_blue expected %0d got %0d", want.mean_blue, got.mean_blue);
      fail_count++;
    end
    if (got.mean_green !== want.mean_green) begin
      $error("mean_green expected %0d got %0d", want.mean_green, got.mean_green);
      fail_count++;
    end
    if (got.mean_red !== want.mean_red) begin
      $error("mean_red expected %0d got %0d", want.mean_red, got.mean_red);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      blk_reg <= 5'd4;
      wid_reg <= 11'd640;
      hgt_reg <= 11'd480;
      restart_frame();
      mean_queue.delete();
    end else begin
      if (mean_valid && mean_ready) compare_mean(mean_data);
      if (pix_valid && pix_ready) accumulate_pixel(pix_data);
      if (cfg_we) begin
        if (cfg_index == RegBlockSize) begin
          blk_reg <= cfg_data[4:0];
          restart_frame();
        end else if (cfg_index == RegImageWidth) begin
          wid_reg <= cfg_data;
          restart_frame();
        end else if (cfg_index == RegImageHeight) begin
          hgt_reg <= cfg_data;
          restart_frame();
        end
      end
    end
    pending_means <= mean_queue.size();
  end

endmodule

// File: dv/tb.sv
// Testbench top for the block mean mosaic: stimulus, receiver stalls and verdict.
module tb;
  import bmm_pkg::*;

  localparam int CycleLimit = 2000000;
  // The longest pixel inside the block is the one that runs the divide.
  localparam int DrainCycles = 60;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int fail_count;
  int pending_means;
  int cycle_count = 0;

  // Idle percentages of each side and the length of a long receiver hold-off.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  bmm_stream_if #(.payload_t(pixel_t)) pixel_in ();
  bmm_stream_if #(.payload_t(mean_t))  mean_out ();

  initial begin
    pixel_in.valid = 1'b0;
    pixel_in.data = '0;
    mean_out.ready = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  block_mean_mosaic_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in.sink),
    .mean_out  (mean_out.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bmm_mean_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pixel_in.valid),
    .pix_ready     (pixel_in.ready),
    .pix_data      (pixel_in.data),
    .mean_valid    (mean_out.valid),
    .mean_ready    (mean_out.ready),
    .mean_data     (mean_out.data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_means (pending_means)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("block_mean_mosaic_top verification failed");
      $finish;
    end
  end

  // Receiver side. A long hold-off request is counted down here while the
  // sender keeps offering pixels, so the block fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      mean_out.ready <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      mean_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      mean_out.ready <= 1'b0;
    end else begin
      mean_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one pixel beat. Valid drops only when the sender decides to idle,
  // so back-to-back beats never lower and raise valid in one step.
  task automatic send_pixel(pixel_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      pixel_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.data <= p;
    do @(posedge clk); while (!pixel_in.ready);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [31:0] raw;
    raw = $urandom;
    p = raw[23:0];
    // Lean on the extremes now and then so saturated sums get exercised.
    if ($urandom_range(7) == 0) p = '1;
    else if ($urandom_range(7) == 0) p = '0;
    return p;
  endfunction

  // Wait until every predicted mean has arrived and the divider is quiet.
  task automatic drain();
    pixel_in.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending_means != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int unsigned bs, int unsigned w, int unsigned h);
    write_reg(RegBlockSize, bs);
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
  endtask

  task automatic run_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(random_pixel());
  endtask

  initial begin
    int mode;
    int npix;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: block size one makes every pixel its own mean, so the
    // field extremes come straight back.
    setup(1, 4, 2);
    send_pixel('0);
    send_pixel('1);
    send_pixel({8'hFF, 8'h00, 8'hFF});
    send_pixel({8'h00, 8'hFF, 8'h00});
    send_pixel(24'h80_7F_01);
    send_pixel(24'h01_02_03);
    send_pixel(24'hAA_55_AA);
    send_pixel(24'h55_AA_55);
    drain();

    // Directed: a 2x2 block whose mean sits on the rounding boundary, a block
    // that ends exactly on the right edge, and a partial bottom row.
    setup(2, 4, 3);
    send_pixel(24'h00_00_00); send_pixel(24'h01_01_01);
    send_pixel(24'hFF_FF_FF); send_pixel(24'hFF_FF_FF);
    send_pixel(24'h01_00_01); send_pixel(24'h00_01_00);
    send_pixel(24'hFF_FE_FF); send_pixel(24'hFE_FF_FE);
    run_pixels(6);
    drain();

    // Zero values read as one and oversize values saturate; the unused
    // index must change nothing.
    setup(0, 0, 0);
    write_reg(RegUnused, 11'h7FF);
    run_pixels(3);
    drain();
    setup(31, 2047, 2047);
    run_pixels(20);
    drain();

    // Largest block over a row with a partial block at its right edge.
    setup(16, 24, 16);
    run_pixels(24 * 16);
    drain();

    // Random phases over small images, cycling through the idling modes.
    for (int ph = 0; ph < 14; ph++) begin
      mode = ph % 4;
      send_idle_pct  = (mode == 1) ? 79 : (mode == 3) ? 17 : 0;
      recv_stall_pct = (mode == 2) ? 79 : (mode == 3) ? 17 : 0;
      if (ph == 5) setup(16, 16, 16);
      else if (ph == 9) setup(1, 1, 1);
      // Every pixel closes a block here, so a held-off receiver backs it up.
      else if (ph == 7) setup(1, 8, 8);
      else setup($urandom_range(1, 4), $urandom_range(1, 24), $urandom_range(1, 12));
      // A further height write after setup restarts the frame again before any pixel.
      if (ph == 2) write_reg(RegImageHeight, $urandom_range(1, 12));
      npix = (ph == 5) ? 256 : 40;
      // One phase holds the receiver off long enough to back up the block.
      if (ph == 7) hold_request = 400;
      run_pixels(npix);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (fail_count == 0) begin
      $display("block_mean_mosaic_top verification clean");
    end else begin
      $display("block_mean_mosaic_top verification failed");
    end
    $finish;
  end

endmodule
